// ===== src/chd_pkg.sv =====
// Shared types and constants for the chunked body decoder.
package chd_pkg;

    // Longest size line accepted, counting CR and LF.
    localparam int LINE_LIMIT = 256;
    // Width of the size-line byte counter: must hold LINE_LIMIT itself.
    localparam int LINE_W     = $clog2(LINE_LIMIT + 1);
    // Most hex digits a chunk size may have.
    localparam int DIGITS_MAX = 8;

    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    // One input transaction.
    typedef struct packed {
        logic [7:0] stream_byte;
        logic       stream_end;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [31:0] body_length;
    } t_out_item;

    // Character classes of one input byte.
    typedef struct packed {
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_lf;
        logic       is_cr;
        logic       is_blank;
    } t_char_class;

endpackage

// ===== src/http_chunked_body_decoder.sv =====
// Top level of the HTTP chunked transfer body decoder.
//
// The input channel carries one raw body byte per transaction, or a stream
// end marker that closes the connection. The output channel carries payload
// bytes, a completion with the total body length, or a framing error. Size
// lines, chunk extensions and the CRLF after each chunk produce no payload bytes.
// Each input transaction yields zero or one result transaction.
// A result is offered on o_out_valid in the cycle after its byte is accepted.
// Throughput is one byte per cycle while the receiver takes each result, set by
// the single result register behind the combinational framing logic.
// Reset (synchronous, active low) returns the framer to the start of a size
// line with a zero body length and empties the result register.
// When the receiver stalls with a result waiting, o_in_ready falls and stays
// low until that result is taken; the waiting result is held unchanged.
// After a completion or an error the framer starts over on the next byte.
module http_chunked_body_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  chd_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output chd_pkg::t_out_item  o_out_data
);

    logic               fire;
    logic               res_valid;
    chd_pkg::t_out_item res;

    assign fire = i_in_valid && o_in_ready;

    chd_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (i_in_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    chd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_load_ok   (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== src/chd_classify.sv =====
// Character classifier: decodes hex digits, CR, LF and blanks of one byte.
module chd_classify (
    input  logic [7:0]          i_byte,
    output chd_pkg::t_char_class o_class
);

    // Hex digit decode in both letter cases, then line control and blank characters.
    always_comb begin
        o_class.is_hex  = 1'b0;
        o_class.hex_val = 4'd0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            o_class.is_hex  = 1'b1;
            o_class.hex_val = 4'(i_byte - 8'h30);
        end else if (i_byte >= 8'h61 && i_byte <= 8'h66) begin
            o_class.is_hex  = 1'b1;
            o_class.hex_val = 4'(i_byte - 8'h57);
        end else if (i_byte >= 8'h41 && i_byte <= 8'h46) begin
            o_class.is_hex  = 1'b1;
            o_class.hex_val = 4'(i_byte - 8'h37);
        end
        o_class.is_lf    = (i_byte == chd_pkg::CHAR_LF);
        o_class.is_cr    = (i_byte == chd_pkg::CHAR_CR);
        o_class.is_blank = (i_byte == chd_pkg::CHAR_SP) || (i_byte == chd_pkg::CHAR_TAB);
    end

endmodule

// ===== src/chd_step.sv =====
// Framing state and combinational next-state logic of the chunked decoder.
module chd_step (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  chd_pkg::t_in_item     i_item,
    output logic                  o_res_valid,
    output chd_pkg::t_out_item    o_res
);

    typedef enum logic [1:0] {
        PH_SIZE = 2'd0,
        PH_DATA = 2'd1,
        PH_CRLF = 2'd2
    } t_phase;

    t_phase                       r_phase,   n_phase;
    logic [31:0]                  r_acc,     n_acc;
    logic [3:0]                   r_digits,  n_digits;
    logic                         r_closed,  n_closed;
    logic [chd_pkg::LINE_W-1:0]   r_line,    n_line;
    logic [31:0]                  r_remain,  n_remain;
    logic                         r_trailer, n_trailer;
    logic [31:0]                  r_total,   n_total;

    chd_pkg::t_char_class         cls;
    logic [chd_pkg::LINE_W-1:0]   line_inc;
    logic                         fin_done;
    logic                         fin_err;

    chd_classify u_classify (
        .i_byte  (i_item.stream_byte),
        .o_class (cls)
    );

    assign line_inc = r_line + 1'b1;

    // Next state and result for the byte on the input.
    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_digits    = r_digits;
        n_closed    = r_closed;
        n_line      = r_line;
        n_remain    = r_remain;
        n_trailer   = r_trailer;
        n_total     = r_total;
        fin_done    = 1'b0;
        fin_err     = 1'b0;
        o_res_valid = 1'b0;
        o_res.kind         = chd_pkg::KIND_BYTE;
        o_res.payload_byte = i_item.stream_byte;
        o_res.body_length  = 32'd0;

        unique case (r_phase)
            PH_DATA: begin
                if (i_item.stream_end) begin
                    fin_err = 1'b1;
                end else begin
                    o_res_valid = 1'b1;
                    if (r_total != 32'hFFFF_FFFF) begin
                        n_total = r_total + 32'd1;
                    end
                    n_remain = r_remain - 32'd1;
                    if (r_remain == 32'd1) begin
                        n_phase   = PH_CRLF;
                        n_trailer = 1'b0;
                    end
                end
            end
            PH_CRLF: begin
                if (i_item.stream_end) begin
                    fin_err = 1'b1;
                end else if (r_trailer) begin
                    n_phase   = PH_SIZE;
                    n_trailer = 1'b0;
                    n_acc     = 32'd0;
                    n_digits  = 4'd0;
                    n_closed  = 1'b0;
                    n_line    = '0;
                end else begin
                    n_trailer = 1'b1;
                end
            end
            default: begin
                // Size line; the unused phase code behaves the same way.
                if (i_item.stream_end) begin
                    if (r_line == '0) begin
                        fin_done = 1'b1;
                    end else begin
                        fin_err = 1'b1;
                    end
                end else begin
                    n_line = line_inc;
                    if (cls.is_lf) begin
                        if (r_digits == 4'd0) begin
                            fin_err = 1'b1;
                        end else if (r_acc == 32'd0) begin
                            fin_done = 1'b1;
                        end else begin
                            n_remain = r_acc;
                            n_phase  = PH_DATA;
                            n_acc    = 32'd0;
                            n_digits = 4'd0;
                            n_closed = 1'b0;
                            n_line   = '0;
                        end
                    end else if (line_inc >= chd_pkg::LINE_W'(chd_pkg::LINE_LIMIT)) begin
                        fin_err = 1'b1;
                    end else if (cls.is_cr || r_closed) begin
                        n_closed = r_closed;
                    end else if (cls.is_hex) begin
                        if (r_digits >= 4'(chd_pkg::DIGITS_MAX)) begin
                            fin_err = 1'b1;
                        end else begin
                            n_acc    = {r_acc[27:0], cls.hex_val};
                            n_digits = r_digits + 4'd1;
                        end
                    end else if (!(cls.is_blank && r_digits == 4'd0)) begin
                        // Any other character ends the digits; extensions follow.
                        n_closed = 1'b1;
                    end
                end
            end
        endcase

        // Done or error ends the body and returns every register to reset.
        if (fin_done || fin_err) begin
            o_res_valid        = 1'b1;
            o_res.kind         = fin_done ? chd_pkg::KIND_DONE : chd_pkg::KIND_ERR;
            o_res.payload_byte = 8'd0;
            o_res.body_length  = fin_done ? r_total : 32'd0;
            n_phase   = PH_SIZE;
            n_acc     = 32'd0;
            n_digits  = 4'd0;
            n_closed  = 1'b0;
            n_line    = '0;
            n_remain  = 32'd0;
            n_trailer = 1'b0;
            n_total   = 32'd0;
        end
    end

    // State registers, advanced once per accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SIZE;
            r_acc     <= 32'd0;
            r_digits  <= 4'd0;
            r_closed  <= 1'b0;
            r_line    <= '0;
            r_remain  <= 32'd0;
            r_trailer <= 1'b0;
            r_total   <= 32'd0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_acc     <= n_acc;
            r_digits  <= n_digits;
            r_closed  <= n_closed;
            r_line    <= n_line;
            r_remain  <= n_remain;
            r_trailer <= n_trailer;
            r_total   <= n_total;
        end
    end

endmodule

// ===== src/chd_out_reg.sv =====
// Result register: holds one result transaction and gives the input side its ready.
module chd_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic                i_res_valid,
    input  chd_pkg::t_out_item  i_res,
    output logic                o_load_ok,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output chd_pkg::t_out_item  o_out_data
);

    logic               r_valid;
    chd_pkg::t_out_item r_data;

    // A new result may enter when the register is empty or is being emptied.
    assign o_load_ok = !r_valid || i_out_ready;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire) begin
            r_valid <= i_res_valid;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload, loaded only with a real result.
    always_ff @(posedge i_clk) begin
        if (i_fire && i_res_valid) begin
            r_data <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

// ===== src/chd_checker.sv =====
// Port-level checks of the chunked body decoder, bound to its top level.
module chd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input chd_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input chd_pkg::t_out_item o_out_data
);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or vanished");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    // An empty result register never blocks the input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty result register");

    // A stream end always closes the body with a completion or an error.
    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.stream_end |=>
            o_out_valid && o_out_data.kind != chd_pkg::KIND_BYTE)
        else $error("stream end gave no completion or error");

    // Only a completion carries a body length.
    a_length_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind != chd_pkg::KIND_DONE |->
            o_out_data.body_length == 32'd0)
        else $error("body length on a non-completion result");

endmodule

bind http_chunked_body_decoder chd_checker u_chd_checker (.*);

// ===== tb/sv/http_chunked_body_decoder_tb.sv =====
// Self-checking testbench for the HTTP chunked body decoder.
module http_chunked_body_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Number of input transactions after which the random stimulus stops.
    localparam int ITEM_TARGET = 1900;

    // Framing phases tracked by the scoreboard's own decoder.
    typedef enum logic [1:0] {
        PH_SIZE = 2'd0,
        PH_DATA = 2'd1,
        PH_CRLF = 2'd2
    } t_phase;

    // Decodes every accepted byte alongside the block and checks its results in order.
    class body_scoreboard;
        t_phase                     phase;
        logic [31:0]                size_acc;
        logic [3:0]                 digit_cnt;
        logic                       digits_closed;
        logic [chd_pkg::LINE_W-1:0] line_len;
        logic [31:0]                bytes_left;
        logic                       crlf_seen;
        logic [31:0]                body_total;
        chd_pkg::t_out_item         decoded_q[$];
        int                         fail_count;

        function new();
            fail_count = 0;
            clear_body();
        endfunction

        function void clear_line();
            size_acc      = '0;
            digit_cnt     = '0;
            digits_closed = 1'b0;
            line_len      = '0;
        endfunction

        function void clear_body();
            phase      = PH_SIZE;
            clear_line();
            bytes_left = '0;
            crlf_seen  = 1'b0;
            body_total = '0;
        endfunction

        function bit hex_digit(logic [7:0] c, output logic [3:0] v);
            v = '0;
            if (c >= "0" && c <= "9") v = 4'(c - "0");
            else if (c >= "a" && c <= "f") v = 4'(c - "a" + 8'd10);
            else if (c >= "A" && c <= "F") v = 4'(c - "A" + 8'd10);
            else return 1'b0;
            return 1'b1;
        endfunction

        // Completion or error: the body ends and the framer starts over.
        function chd_pkg::t_out_item close_body(chd_pkg::t_kind k);
            chd_pkg::t_out_item res;
            res      = '0;
            res.kind = k;
            if (k == chd_pkg::KIND_DONE) res.body_length = body_total;
            clear_body();
            return res;
        endfunction

        // One byte or stream end through the framer; returns 1 when it yields a result.
        function bit decode_step(chd_pkg::t_in_item it, output chd_pkg::t_out_item res);
            logic [7:0] c;
            logic [3:0] v;
            c   = it.stream_byte;
            res = '0;

            // Chunk data passes straight through.
            if (phase == PH_DATA) begin
                if (it.stream_end) begin
                    res = close_body(chd_pkg::KIND_ERR);
                    return 1'b1;
                end
                if (body_total != 32'hFFFF_FFFF) body_total = body_total + 1;
                bytes_left = bytes_left - 1;
                if (bytes_left == 0) begin
                    phase     = PH_CRLF;
                    crlf_seen = 1'b0;
                end
                res.kind         = chd_pkg::KIND_BYTE;
                res.payload_byte = c;
                return 1'b1;
            end

            // The two bytes after the data are dropped without a look.
            if (phase == PH_CRLF) begin
                if (it.stream_end) begin
                    res = close_body(chd_pkg::KIND_ERR);
                    return 1'b1;
                end
                if (crlf_seen) begin
                    phase     = PH_SIZE;
                    crlf_seen = 1'b0;
                    clear_line();
                end else begin
                    crlf_seen = 1'b1;
                end
                return 1'b0;
            end

            // Size line.
            if (it.stream_end) begin
                res = close_body(line_len == 0 ? chd_pkg::KIND_DONE : chd_pkg::KIND_ERR);
                return 1'b1;
            end
            line_len = line_len + 1;
            if (c == chd_pkg::CHAR_LF) begin
                if (digit_cnt == 0) begin
                    res = close_body(chd_pkg::KIND_ERR);
                    return 1'b1;
                end
                if (size_acc == 0) begin
                    res = close_body(chd_pkg::KIND_DONE);
                    return 1'b1;
                end
                bytes_left = size_acc;
                phase      = PH_DATA;
                clear_line();
                return 1'b0;
            end
            if (line_len >= chd_pkg::LINE_LIMIT) begin
                res = close_body(chd_pkg::KIND_ERR);
                return 1'b1;
            end
            if (c == chd_pkg::CHAR_CR || digits_closed) return 1'b0;
            if (hex_digit(c, v)) begin
                if (digit_cnt >= chd_pkg::DIGITS_MAX) begin
                    res = close_body(chd_pkg::KIND_ERR);
                    return 1'b1;
                end
                size_acc  = {size_acc[27:0], v};
                digit_cnt = digit_cnt + 1;
                return 1'b0;
            end
            if ((c == chd_pkg::CHAR_SP || c == chd_pkg::CHAR_TAB) && digit_cnt == 0) return 1'b0;
            digits_closed = 1'b1;
            return 1'b0;
        endfunction

        function void note_input(chd_pkg::t_in_item it);
            chd_pkg::t_out_item res;
            if (decode_step(it, res)) decoded_q.push_back(res);
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

        function void report(string what, logic [31:0] want, logic [31:0] got);
            fail_count++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        endfunction

        function void check_result(chd_pkg::t_out_item got);
            chd_pkg::t_out_item want;
            if (decoded_q.size() == 0) begin
                fail_count++;
                $display("%0t ns: unexpected result, expected none, got kind %0d byte %0h len %0h",
                         $time, got.kind, got.payload_byte, got.body_length);
                return;
            end
            want = decoded_q.pop_front();
            if (got.kind !== want.kind) report("kind", want.kind, got.kind);
            if (got.payload_byte !== want.payload_byte)
                report("payload_byte", want.payload_byte, got.payload_byte);
            if (got.body_length !== want.body_length)
                report("body_length", want.body_length, got.body_length);
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    chd_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    chd_pkg::t_out_item o_out_data;

    body_scoreboard    board;
    chd_pkg::t_in_item tx_bytes[$];
    int                bytes_sent  = 0;
    bit                sender_calm = 1'b0;
    bit                recv_calm   = 1'b0;

    http_chunked_body_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Stimulus builders: each appends input transactions to the send queue.
    function automatic void push_byte(logic [7:0] b);
        chd_pkg::t_in_item it;
        it.stream_byte = b;
        it.stream_end  = 1'b0;
        tx_bytes.push_back(it);
    endfunction

    function automatic void push_end();
        chd_pkg::t_in_item it;
        it.stream_byte = 8'($urandom_range(0, 255));
        it.stream_end  = 1'b1;
        tx_bytes.push_back(it);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endfunction

    function automatic void push_crlf();
        push_byte(chd_pkg::CHAR_CR);
        push_byte(chd_pkg::CHAR_LF);
    endfunction

    function automatic logic [7:0] non_lf_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == chd_pkg::CHAR_LF);
        return b;
    endfunction

    function automatic logic [7:0] hex_char();
        string hex_set;
        hex_set = "0123456789abcdefABCDEF";
        return hex_set[$urandom_range(0, 21)];
    endfunction

    // Mostly short chunks, now and then a longer one.
    function automatic int unsigned pick_size();
        if ($urandom_range(0, 39) == 0) return $urandom_range(200, 300);
        if ($urandom_range(0, 9) == 0) return $urandom_range(13, 64);
        return $urandom_range(1, 12);
    endfunction

    // Chunk extension, or anything else that closes the digits.
    function automatic void push_extension();
        string closers;
        closers = "; -x+";
        push_byte(closers[$urandom_range(0, 4)]);
        repeat ($urandom_range(0, 8)) push_byte(non_lf_byte());
    endfunction

    // Size line with random case, padding zeros, blanks, extension and optional CR.
    function automatic void push_size_line(int unsigned size);
        string      digits;
        logic [7:0] c;
        digits = $sformatf("%0h", size);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(0, chd_pkg::DIGITS_MAX - digits.len())) digits = {"0", digits};
        if ($urandom_range(0, 3) == 0)
            push_byte($urandom_range(0, 1) ? chd_pkg::CHAR_SP : chd_pkg::CHAR_TAB);
        for (int i = 0; i < digits.len(); i++) begin
            c = digits[i];
            if (c >= "a" && $urandom_range(0, 1)) c = c - 8'h20;
            push_byte(c);
        end
        if ($urandom_range(0, 3) == 0) push_extension();
        if ($urandom_range(0, 5) != 0) push_byte(chd_pkg::CHAR_CR);
        push_byte(chd_pkg::CHAR_LF);
    endfunction

    // A well-formed body: a few chunks and one of the ways a body may end.
    function automatic void push_body();
        int unsigned size;
        repeat ($urandom_range(0, 3)) begin
            size = pick_size();
            push_size_line(size);
            repeat (size) push_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 5) == 0) begin
                push_byte(8'($urandom_range(0, 255)));
                push_byte(8'($urandom_range(0, 255)));
            end else begin
                push_crlf();
            end
        end
        case ($urandom_range(0, 9))
            0, 1: push_end();
            2: begin
                push_text("0x1f");
                push_crlf();
            end
            3: begin
                // A trailer section's blank line is read as a new size line with no digits, an error.
                push_size_line(0);
                push_crlf();
            end
            default: push_size_line(0);
        endcase
    endfunction

    function automatic void load_directed();
        // Stream end on an empty size line completes an empty body.
        push_end();
        // A size line with no digits at all.
        push_byte(chd_pkg::CHAR_LF);
        // Blanks, an extension, the top byte value and a zero-size end.
        push_byte(chd_pkg::CHAR_SP);
        push_byte(chd_pkg::CHAR_TAB);
        push_text("1;x");
        push_crlf();
        push_byte(8'hFF);
        push_crlf();
        push_text("0");
        push_byte(chd_pkg::CHAR_LF);
        // Short data read.
        push_text("2");
        push_byte(chd_pkg::CHAR_LF);
        push_byte(8'h00);
        push_end();
        // Stream end within a size line.
        push_text("aF");
        push_end();
        // Stream end within the CRLF after the data.
        push_text("1");
        push_byte(chd_pkg::CHAR_LF);
        push_byte(8'h5A);
        push_byte(chd_pkg::CHAR_CR);
        push_end();
    endfunction

    function automatic void load_random_sequence();
        int pick;
        int start;
        int cut;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            push_body();
        end else if (pick < 70) begin
            // Body cut short at any point by the connection closing.
            start = tx_bytes.size();
            push_body();
            cut = $urandom_range(start, tx_bytes.size() - 1);
            while (tx_bytes.size() > cut) void'(tx_bytes.pop_back());
            push_end();
        end else if (pick < 75) begin
            // More hex digits than a size may hold.
            repeat ($urandom_range(chd_pkg::DIGITS_MAX + 1, chd_pkg::DIGITS_MAX + 2))
                push_byte(hex_char());
            push_crlf();
        end else if (pick < 80) begin
            // Full-width size, then the stream closes a few bytes in.
            if ($urandom_range(0, 1)) push_text("FFFFFFFF");
            else repeat (chd_pkg::DIGITS_MAX) push_byte(hex_char());
            push_crlf();
            repeat ($urandom_range(0, 6)) push_byte(8'($urandom_range(0, 255)));
            push_end();
        end else if (pick < 85) begin
            case ($urandom_range(0, 2))
                0: push_crlf();
                1: push_text(" ;ext");
                default: push_text("-1");
            endcase
            push_byte(chd_pkg::CHAR_LF);
        end else if (pick < 87) begin
            // Size line right at the length limit, or one byte over it.
            push_text("1;");
            repeat (chd_pkg::LINE_LIMIT - 3 + $urandom_range(0, 1)) push_byte(non_lf_byte());
            push_byte(chd_pkg::CHAR_LF);
            push_byte(8'($urandom_range(0, 255)));
            push_crlf();
        end else begin
            repeat ($urandom_range(1, 16)) begin
                if ($urandom_range(0, 7) == 0) push_end();
                else push_byte(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    // Sends everything queued, with a random gap before each transaction.
    task automatic send_queue();
        chd_pkg::t_in_item it;
        int                gap;
        while (tx_bytes.size() > 0) begin
            it = tx_bytes.pop_front();
            if ($urandom_range(0, 63) == 0) sender_calm = !sender_calm;
            gap = sender_calm ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_data  <= it;
            do @(posedge i_clk); while (o_in_ready !== 1'b1);
            board.note_input(it);
            bytes_sent++;
        end
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // Result side: random stalls, with calm stretches of none.
    initial begin
        int stall;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
            stall = recv_calm ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    // Every result transaction is checked against the oldest outstanding one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) board.check_result(o_out_data);
    end

    // Main sequence: reset, directed bytes, a full drain, then random bodies.
    initial begin
        int guard;
        board = new();
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_directed();
        send_queue();
        hold_until_drained();

        while (bytes_sent < ITEM_TARGET) begin
            load_random_sequence();
            send_queue();
            if ($urandom_range(0, 24) == 0) hold_until_drained();
        end
        i_in_valid <= 1'b0;

        guard = 0;
        while (board.pending() != 0 && guard < 4000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        if (board.pending() != 0) begin
            $display("%0t ns: %0d results still outstanding", $time, board.pending());
            board.fail_count++;
        end

        if (board.fail_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    // Watchdog.
    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/chd_pkg.sv
src/chd_classify.sv
src/chd_step.sv
src/chd_out_reg.sv
src/http_chunked_body_decoder.sv
src/chd_checker.sv
tb/sv/http_chunked_body_decoder_tb.sv
